// ----- sv/rpwd_pkg.sv -----
// Shared types, constants and codes for the RF pulse-width decoder.
package rpwd_pkg;

   localparam int SAMPLE_W  = 10;
   localparam int RUN_W     = 8;
   localparam int COUNT_W   = 7;
   localparam int FRAME_W   = 64;
   localparam int EVENT_W   = 2;
   localparam int MATCH_W   = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 64;

   localparam int MAX_BITS_DEFAULT = 64;

   localparam logic [RUN_W-1:0] RUN_MAX      = 8'd255;
   localparam logic [RUN_W-1:0] DATA_MIN     = 8'd1;
   localparam logic [RUN_W-1:0] DATA_MAX     = 8'd5;
   localparam logic [RUN_W-1:0] DOUBLE_MIN   = 8'd3;
   localparam logic [RUN_W-1:0] DELIM_MIN    = 8'd36;
   localparam logic [RUN_W-1:0] DELIM_MAX    = 8'd40;

   localparam logic [SAMPLE_W-1:0] LOW_THR_RESET  = 10'd170;
   localparam logic [SAMPLE_W-1:0] HIGH_THR_RESET = 10'd690;

   typedef enum logic [EVENT_W-1:0] {
      EV_BIT_STORED = 2'd0,
      EV_FRAME_END  = 2'd1,
      EV_DECODE_ERR = 2'd2,
      EV_BAD_LENGTH = 2'd3
   } event_type;

   localparam logic [MATCH_W-1:0] MATCH_NONE = 2'd0;
   localparam logic [MATCH_W-1:0] MATCH_ON   = 2'd1;
   localparam logic [MATCH_W-1:0] MATCH_OFF  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_ON   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_OFF  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_LEN  = 3'd4;

   // A finished run, reported on the sample that changes the line level.
   typedef struct packed {
      logic             valid;
      logic             level;
      logic [RUN_W-1:0] len;
   } run_type;

   typedef struct packed {
      event_type          event_res;
      logic [COUNT_W-1:0] frame_bits;
      logic [FRAME_W-1:0] frame_word;
      logic [MATCH_W-1:0] match;
      logic               lamp;
   } result_type;

endpackage

// ----- sv/rf_pulse_width_decoder_unit.sv -----
// Top level of the RF pulse-width decoder: registers, channels and result stage.
//
// The block takes one 10-bit converter sample per req_ beat and slices it into a
// line level using the low and high thresholds, with a dead band between them.
// Each change of level finishes a run, and that run is classified: data bits are
// stored, a frame ends (and may match the on or off code, which switches the lamp),
// or an error clears the frame. Only samples that change the level give a rsp_
// beat; all other samples are absorbed with no result.
// A sample is captured in the input register, and the classifier works straight
// out of it into the result register, which drives rsp_tvalid. While the receiver
// takes results, the block takes a sample in every cycle; the line state, run
// counters and bit store are updated in that single classifier stage, so
// back-to-back samples need no stall.
// When the receiver holds rsp_tready low, the result register holds its beat and
// the input register keeps one sample; req_tready falls only when both are full.
// Reset is synchronous and active high. It clears the line state, the counters,
// the frame store and the lamp, empties both stages and loads the register defaults
// (thresholds 170 and 690, codes and code length zero). The user must write the
// registers via csr_ (always ready) only while idle; the block does not enforce it.
module rf_pulse_width_decoder_unit #(
   parameter int MAX_BITS = rpwd_pkg::MAX_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // tdata: sample[9:0], zero fill [15:10]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,
   // tdata: frame_bits[6:0], frame_word[70:7], match[72:71], lamp[73],
   // zero fill [79:74]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [79:0]                     rsp_tdata,
   // tuser: event_res[1:0]
   output logic [1:0]                      rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rpwd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rpwd_pkg::CSR_DAT_W-1:0]  csr_data
);

   logic [rpwd_pkg::SAMPLE_W-1:0]  low_thr_ff, high_thr_ff;
   logic [rpwd_pkg::FRAME_W-1:0]   code_on_ff, code_off_ff;
   logic [rpwd_pkg::COUNT_W-1:0]   code_len_ff;

   logic [rpwd_pkg::SAMPLE_W-1:0]  sample_ff;
   logic                           sample_vld_ff;
   logic                           rsp_vld_ff;
   rpwd_pkg::result_type           rsp_ff, result;
   rpwd_pkg::run_type              run;
   logic                           step, req_take;

   // The classifier advances when it holds a sample and the result slot is free.
   assign step       = sample_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !sample_vld_ff || step;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_thr_ff  <= rpwd_pkg::LOW_THR_RESET;
         high_thr_ff <= rpwd_pkg::HIGH_THR_RESET;
         code_on_ff  <= '0;
         code_off_ff <= '0;
         code_len_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            rpwd_pkg::CSR_LOW_THR:  low_thr_ff  <= csr_data[rpwd_pkg::SAMPLE_W-1:0];
            rpwd_pkg::CSR_HIGH_THR: high_thr_ff <= csr_data[rpwd_pkg::SAMPLE_W-1:0];
            rpwd_pkg::CSR_CODE_ON:  code_on_ff  <= csr_data[rpwd_pkg::FRAME_W-1:0];
            rpwd_pkg::CSR_CODE_OFF: code_off_ff <= csr_data[rpwd_pkg::FRAME_W-1:0];
            rpwd_pkg::CSR_CODE_LEN: code_len_ff <= csr_data[rpwd_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_vld_ff <= 1'b0;
      end else if (req_take) begin
         sample_vld_ff <= 1'b1;
      end else if (step) begin
         sample_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= req_tdata[rpwd_pkg::SAMPLE_W-1:0];
      end
   end

   rpwd_run_tracker u_run_tracker (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .sample   (sample_ff),
      .low_thr  (low_thr_ff),
      .high_thr (high_thr_ff),
      .run      (run)
   );

   rpwd_frame_decoder #(
      .MAX_BITS (MAX_BITS)
   ) u_frame_decoder (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .run      (run),
      .code_on  (code_on_ff),
      .code_off (code_off_ff),
      .code_len (code_len_ff),
      .result   (result)
   );

   // Result register: loaded only by samples that close a run.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (step && run.valid) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && run.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_ff.event_res;
   assign rsp_tdata  = {6'd0, rsp_ff.lamp, rsp_ff.match, rsp_ff.frame_word,
                        rsp_ff.frame_bits};

endmodule

// ----- sv/rpwd_run_tracker.sv -----
// Line level slicer and saturating run-length counters.
module rpwd_run_tracker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [rpwd_pkg::SAMPLE_W-1:0]   sample,
   input  logic [rpwd_pkg::SAMPLE_W-1:0]   low_thr,
   input  logic [rpwd_pkg::SAMPLE_W-1:0]   high_thr,
   output rpwd_pkg::run_type               run
);

   logic                         line_ff, line_in;
   logic [rpwd_pkg::RUN_W-1:0]   low_run_ff, low_run_in;
   logic [rpwd_pkg::RUN_W-1:0]   high_run_ff, high_run_in;
   logic                         is_low, is_high;

   // The low check wins when the thresholds cross.
   assign is_low  = sample < low_thr;
   assign is_high = !is_low && (sample > high_thr);

   always_comb begin
      run.valid = 1'b0;
      run.level = 1'b0;
      run.len   = high_run_ff;
      line_in     = line_ff;
      low_run_in  = low_run_ff;
      high_run_in = high_run_ff;
      if (is_low) begin
         if (line_ff) begin
            run.valid   = 1'b1;
            run.level   = 1'b1;
            run.len     = high_run_ff;
            line_in     = 1'b0;
            high_run_in = '0;
         end
         if (low_run_ff != rpwd_pkg::RUN_MAX) begin
            low_run_in = low_run_ff + 1'b1;
         end
      end else if (is_high) begin
         if (!line_ff) begin
            run.valid  = 1'b1;
            run.level  = 1'b0;
            run.len    = low_run_ff;
            line_in    = 1'b1;
            low_run_in = '0;
         end
         if (high_run_ff != rpwd_pkg::RUN_MAX) begin
            high_run_in = high_run_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff     <= 1'b0;
         low_run_ff  <= '0;
         high_run_ff <= '0;
      end else if (step) begin
         line_ff     <= line_in;
         low_run_ff  <= low_run_in;
         high_run_ff <= high_run_in;
      end
   end

endmodule

// ----- sv/rpwd_frame_decoder.sv -----
// Run classification, bit store, code compare and lamp state.
module rpwd_frame_decoder #(
   parameter int MAX_BITS = rpwd_pkg::MAX_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  rpwd_pkg::run_type               run,
   input  logic [rpwd_pkg::FRAME_W-1:0]    code_on,
   input  logic [rpwd_pkg::FRAME_W-1:0]    code_off,
   input  logic [rpwd_pkg::COUNT_W-1:0]    code_len,
   output rpwd_pkg::result_type            result
);

   localparam logic [rpwd_pkg::COUNT_W-1:0] FULL = rpwd_pkg::COUNT_W'(MAX_BITS);

   logic                           started_ff, started_in;
   logic [MAX_BITS-1:0]            store_ff, store_in;
   logic [rpwd_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                           lamp_ff, lamp_in;

   logic                           is_data, is_delim, is_double;
   logic                           fail_first, fail_second;
   logic [MAX_BITS-1:0]            bit_vec, store_one, store_two, mask;
   logic [rpwd_pkg::COUNT_W-1:0]   count_one, count_two;
   logic [MAX_BITS-1:0]            word;
   logic [rpwd_pkg::COUNT_W-1:0]   bits;
   logic                           on_hit, off_hit;

   assign is_data   = started_ff && (run.len >= rpwd_pkg::DATA_MIN)
                      && (run.len <= rpwd_pkg::DATA_MAX);
   assign is_delim  = (run.len >= rpwd_pkg::DELIM_MIN) && (run.len <= rpwd_pkg::DELIM_MAX);
   assign is_double = run.len >= rpwd_pkg::DOUBLE_MIN;

   // A frame must not open with a zero bit, and the store must have room.
   assign bit_vec     = {{(MAX_BITS-1){1'b0}}, run.level};
   assign fail_first  = ((count_ff == '0) && !run.level) || (count_ff >= FULL);
   assign store_one   = store_ff | (bit_vec << count_ff);
   assign count_one   = count_ff + 1'b1;
   assign fail_second = !fail_first && is_double && (count_one >= FULL);
   assign store_two   = store_one | (bit_vec << count_one);
   assign count_two   = count_ff + 2'd2;

   always_comb begin
      for (int i = 0; i < MAX_BITS; i++) begin
         mask[i] = rpwd_pkg::COUNT_W'(i) < count_ff;
      end
   end

   // Bits above the count are always zero in the store.
   assign on_hit  = (count_ff == code_len)
                    && (((store_ff ^ code_on[MAX_BITS-1:0]) & mask) == '0);
   assign off_hit = (count_ff == code_len)
                    && (((store_ff ^ code_off[MAX_BITS-1:0]) & mask) == '0);

   always_comb begin
      started_in = started_ff;
      store_in   = '0;
      count_in   = '0;
      lamp_in    = lamp_ff;
      word       = store_ff;
      bits       = count_ff;
      result.match     = rpwd_pkg::MATCH_NONE;
      result.event_res = rpwd_pkg::EV_BAD_LENGTH;
      if (is_data) begin
         if (fail_first) begin
            word = store_ff;
            bits = count_ff;
         end else if (is_double && !fail_second) begin
            word = store_two;
            bits = count_two;
         end else begin
            word = store_one;
            bits = count_one;
         end
         if (fail_first || fail_second) begin
            result.event_res = rpwd_pkg::EV_DECODE_ERR;
            started_in       = 1'b0;
         end else begin
            result.event_res = rpwd_pkg::EV_BIT_STORED;
            store_in         = word;
            count_in         = bits;
         end
      end else if (is_delim) begin
         if (run.level) begin
            result.event_res = rpwd_pkg::EV_DECODE_ERR;
            started_in       = 1'b0;
         end else begin
            result.event_res = rpwd_pkg::EV_FRAME_END;
            if (started_ff) begin
               if (on_hit) begin
                  result.match = rpwd_pkg::MATCH_ON;
                  lamp_in      = 1'b1;
               end else if (off_hit) begin
                  result.match = rpwd_pkg::MATCH_OFF;
                  lamp_in      = 1'b0;
               end
            end
            started_in = 1'b1;
         end
      end else begin
         started_in = 1'b0;
      end
      result.frame_bits = bits;
      result.frame_word = rpwd_pkg::FRAME_W'(word);
      result.lamp       = lamp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         store_ff   <= '0;
         count_ff   <= '0;
         lamp_ff    <= 1'b0;
      end else if (step && run.valid) begin
         started_ff <= started_in;
         store_ff   <= store_in;
         count_ff   <= count_in;
         lamp_ff    <= lamp_in;
      end
   end

endmodule
